// ===== hdl/vpld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpld_pkg
// Widths and shared types for the vanishing point line distance pipeline.
// ----------------------------------------------------------------------------
package vpld_pkg;

    localparam int COORD_WIDTH = 32;                          // coordinate and result width
    localparam int DW    = COORD_WIDTH + 2;                   // line coefficient l0, l1
    localparam int AW    = COORD_WIDTH + 1;                   // start minus end
    localparam int PW    = DW + AW;                           // dot product, signed
    localparam int NAW   = PW - 1;                            // dot product magnitude
    localparam int HW    = NAW - NAW / 2;                     // upper half of magnitude
    localparam int LW    = NAW / 2;                           // lower half of magnitude
    localparam int N2W   = 2 * NAW;                           // squared magnitude
    localparam int DENW  = 2 * DW;                            // l0^2 + l1^2
    localparam int TW    = DENW + COORD_WIDTH;                // den * partial root
    localparam int SW    = DENW + 2 * COORD_WIDTH + 3;        // root search compare width

    typedef struct packed {
        logic vld;
        logic deg;
    } t_ctl;

endpackage

// ===== hdl/vpld_root.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpld_root
// Pipelined bit-by-bit search for the largest r with 4*r^2*den <= n^2,
// one result bit per stage, using only shifts, adds and compares.
// ----------------------------------------------------------------------------
module vpld_root
    import vpld_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctl                   i_ctl,
    input  logic [N2W-1:0]         i_n2,
    input  logic [DENW-1:0]        i_den,
    output t_ctl                   o_ctl,
    output logic [COORD_WIDTH-1:0] o_root
);

    t_ctl                   r_ctl  [1:COORD_WIDTH];
    logic [SW-1:0]          r_rem  [1:COORD_WIDTH];
    logic [TW-1:0]          r_prod [1:COORD_WIDTH];
    logic [COORD_WIDTH-1:0] r_root [1:COORD_WIDTH];
    logic [DENW-1:0]        r_den  [1:COORD_WIDTH];

    genvar k;
    generate
        for (k = 0; k < COORD_WIDTH; k++) begin : g_stage
            localparam int B = COORD_WIDTH - 1 - k;

            t_ctl                   w_ctl;
            logic [SW-1:0]          w_rem;
            logic [TW-1:0]          w_prod;
            logic [COORD_WIDTH-1:0] w_root;
            logic [DENW-1:0]        w_den;
            logic [SW-1:0]          w_sub;
            logic                   w_ok;

            if (k == 0) begin : g_first
                assign w_ctl  = i_ctl;
                assign w_rem  = SW'(i_n2);
                assign w_prod = '0;
                assign w_root = '0;
                assign w_den  = i_den;
            end else begin : g_next
                assign w_ctl  = r_ctl[k];
                assign w_rem  = r_rem[k];
                assign w_prod = r_prod[k];
                assign w_root = r_root[k];
                assign w_den  = r_den[k];
            end

            // 4*((r+2^b)^2 - r^2)*den = den*r*2^(b+3) + den*2^(2b+2)
            assign w_sub = (SW'(w_prod) << (B + 3)) + (SW'(w_den) << (2 * B + 2));
            assign w_ok  = (w_rem >= w_sub);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[k+1] <= '0;
                end else begin
                    r_ctl[k+1] <= w_ctl;
                end
                r_rem[k+1]  <= w_ok ? (w_rem - w_sub) : w_rem;
                r_prod[k+1] <= w_ok ? (w_prod + (TW'(w_den) << B)) : w_prod;
                r_root[k+1] <= w_root | (COORD_WIDTH'(w_ok) << B);
                r_den[k+1]  <= w_den;
            end
        end
    endgenerate

    assign o_ctl  = r_ctl[COORD_WIDTH];
    assign o_root = r_root[COORD_WIDTH];

`ifndef SYNTHESIS
    a_first_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_ctl[1] == $past(i_ctl))
        else $error("root pipeline dropped a control word at entry");
    a_last_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_ctl[COORD_WIDTH] == $past(r_ctl[COORD_WIDTH-1]))
        else $error("root pipeline dropped a control word at exit");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[1].vld |-> r_rem[1] <= $past(SW'(i_n2)))
        else $error("remainder grew in the first stage");
`endif

endmodule

// ===== hdl/vanishing_point_line_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vanishing_point_line_distance
// Distance from a segment start point to the line through the segment
// midpoint and a candidate vanishing point.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the six coordinates and pulse start; an item is taken at each edge
//   where start is high and busy is low. busy stays low, so one item can be
//   taken in every cycle.
//   Each result appears on o_distance / o_degenerate for exactly one cycle,
//   flagged by o_valid, in the order the items were taken. The receiver
//   cannot hold results off; every item yields exactly one result.
//   Pipeline: 6 front stages (coefficients, products, sums, magnitude,
//   square partial products, square sum), COORD_WIDTH root stages (one
//   result bit each) and one output register.
//   Throughput is one item per cycle; the root search is fully unrolled
//   into stages, so no unit is shared between items.
//   A degenerate item (vanishing point on the midpoint) gives distance 0 and
//   o_degenerate high. Distances above the 32-bit range saturate.
//   Reset clears all valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
module vanishing_point_line_distance
    import vpld_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_vanish_x,
    input  logic signed [COORD_WIDTH-1:0] i_vanish_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_y,
    output logic                          o_valid,
    output logic [COORD_WIDTH-1:0]        o_distance,
    output logic                          o_degenerate
);

    localparam int XW = DW - COORD_WIDTH;

    // stage 1: line coefficients and start-end difference
    logic                 r_v1;
    logic signed [DW-1:0] r_d0, r_d1;
    logic signed [AW-1:0] r_ax, r_ay;
    logic signed [DW-1:0] w_vx, w_vy, w_sx, w_sy, w_ex, w_ey;

    // stage 2: products
    t_ctl                   r_c2;
    logic signed [PW-1:0]   r_p0, r_p1;
    logic signed [DENW-1:0] r_q0, r_q1;

    // stage 3: dot product and denominator
    t_ctl                 r_c3;
    logic signed [PW-1:0] r_n;
    logic [DENW-1:0]      r_den3;

    // stage 4: magnitude
    t_ctl             r_c4;
    logic [NAW-1:0]   r_na;
    logic [DENW-1:0]  r_den4;

    // stage 5: square partial products
    t_ctl              r_c5;
    logic [2*HW-1:0]   r_hh;
    logic [HW+LW-1:0]  r_hl;
    logic [2*LW-1:0]   r_ll;
    logic [DENW-1:0]   r_den5;

    // stage 6: square
    t_ctl             r_c6;
    logic [N2W-1:0]   r_n2;
    logic [DENW-1:0]  r_den6;

    t_ctl                   w_root_ctl;
    logic [COORD_WIDTH-1:0] w_root;
    logic                   w_take;

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    assign w_vx = {{XW{i_vanish_x[COORD_WIDTH-1]}}, i_vanish_x};
    assign w_vy = {{XW{i_vanish_y[COORD_WIDTH-1]}}, i_vanish_y};
    assign w_sx = {{XW{i_seg_start_x[COORD_WIDTH-1]}}, i_seg_start_x};
    assign w_sy = {{XW{i_seg_start_y[COORD_WIDTH-1]}}, i_seg_start_y};
    assign w_ex = {{XW{i_seg_end_x[COORD_WIDTH-1]}}, i_seg_end_x};
    assign w_ey = {{XW{i_seg_end_y[COORD_WIDTH-1]}}, i_seg_end_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else begin
            r_v1     <= w_take;
            r_c2.vld <= r_v1;
            r_c2.deg <= (r_d0 == '0) && (r_d1 == '0);
            r_c3     <= r_c2;
            r_c4     <= r_c3;
            r_c5     <= r_c4;
            r_c6     <= r_c5;
        end

        // coefficients in half units of the input scale
        r_d0 <= w_sy + w_ey - (w_vy <<< 1);
        r_d1 <= (w_vx <<< 1) - w_sx - w_ex;
        r_ax <= AW'(w_sx - w_ex);
        r_ay <= AW'(w_sy - w_ey);

        r_p0 <= PW'(r_d0) * PW'(r_ax);
        r_p1 <= PW'(r_d1) * PW'(r_ay);
        r_q0 <= DENW'(r_d0) * DENW'(r_d0);
        r_q1 <= DENW'(r_d1) * DENW'(r_d1);

        r_n    <= r_p0 + r_p1;
        r_den3 <= DENW'(r_q0 + r_q1);

        r_na   <= r_n[PW-1] ? NAW'(-r_n) : NAW'(r_n);
        r_den4 <= r_den3;

        r_hh   <= (2*HW)'(r_na[NAW-1:LW]) * (2*HW)'(r_na[NAW-1:LW]);
        r_hl   <= (HW+LW)'(r_na[NAW-1:LW]) * (HW+LW)'(r_na[LW-1:0]);
        r_ll   <= (2*LW)'(r_na[LW-1:0]) * (2*LW)'(r_na[LW-1:0]);
        r_den5 <= r_den4;

        r_n2   <= (N2W'(r_hh) << (2 * LW)) + (N2W'(r_hl) << (LW + 1)) + N2W'(r_ll);
        r_den6 <= r_den5;
    end

    vpld_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_c6),
        .i_n2    (r_n2),
        .i_den   (r_den6),
        .o_ctl   (w_root_ctl),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid      <= 1'b0;
            o_degenerate <= 1'b0;
        end else begin
            o_valid      <= w_root_ctl.vld;
            o_degenerate <= w_root_ctl.vld && w_root_ctl.deg;
        end
        // a zero denominator passes every test, so the root is masked here
        o_distance <= w_root_ctl.deg ? '0 : w_root;
    end

`ifndef SYNTHESIS
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_distance == '0)
        else $error("degenerate result with nonzero distance");
    a_deg_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_degenerate |-> o_valid)
        else $error("degenerate flag outside a result cycle");
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_valid == $past(w_root_ctl.vld))
        else $error("result strobe lost or invented at output");
    a_front_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_v1 == $past(w_take))
        else $error("accepted transfer not entered into pipeline");
`endif

endmodule
